### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside of reset
`define OX_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds
`define OX_ASSERT_NEVER(name, clk, rst, cond, msg) \
   `OX_ASSERT(name, clk, rst, !(cond), msg)

`else

`define OX_ASSERT(name, clk, rst, prop, msg)

`define OX_ASSERT_NEVER(name, clk, rst, cond, msg)

`endif

`endif

### hdl/ox_pkg.sv
// ----------------------------------------------------------------------------
// Ordered crossover package
// Sizes, payload types and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ox_pkg;

   // Sizes
   localparam int MAX_NODES  = 64;
   localparam int NODE_RANGE = 256;
   localparam int NODE_W     = 8;
   localparam int CUT_W      = 6;
   localparam int POS_W      = 6;
   localparam int ADDR_W     = $clog2(MAX_NODES);
   localparam int CNT_W      = $clog2(MAX_NODES + 1);
   localparam int SEEN_W     = $clog2(NODE_RANGE);

   // Input item
   typedef struct packed {
      logic [NODE_W-1:0] parent_a_node;
      logic [NODE_W-1:0] parent_b_node;
      logic [CUT_W-1:0]  cut_first;
      logic [CUT_W-1:0]  cut_second;
      logic              last_item;
   } req_type;

   // Result item
   typedef struct packed {
      logic [NODE_W-1:0] child_node;
      logic [POS_W-1:0]  child_position;
      logic              last_result;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic prep;
      logic seg_step;
      logic fill_step;
      logic emit_read;
      logic emit_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic seg_last;
      logic fill_last;
      logic emit_last;
      logic out_free;
   } sts_type;

endpackage

### hdl/ox_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one parent position per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ox_req_if;
   import ox_pkg::*;

   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] parent_a_node;
   logic [NODE_W-1:0] parent_b_node;
   logic [CUT_W-1:0]  cut_first;
   logic [CUT_W-1:0]  cut_second;
   logic              last_item;

   modport source (
      output valid, parent_a_node, parent_b_node, cut_first, cut_second, last_item,
      input  ready
   );

   modport sink (
      input  valid, parent_a_node, parent_b_node, cut_first, cut_second, last_item,
      output ready
   );

endinterface

### hdl/ox_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one child position per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ox_rsp_if;
   import ox_pkg::*;

   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] child_node;
   logic [POS_W-1:0]  child_position;
   logic              last_result;

   modport source (
      output valid, child_node, child_position, last_result,
      input  ready
   );

   modport sink (
      input  valid, child_node, child_position, last_result,
      output ready
   );

endinterface

### hdl/ox_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered crossover controller
// Sequences load, segment copy, fill from parent B and child readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ox_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   output logic            req_ready,
   input  ox_pkg::sts_type sts,
   output ox_pkg::cmd_type cmd
);
   import ox_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_PREP    = 7'b0000010,
      ST_SEG     = 7'b0000100,
      ST_FILL    = 7'b0001000,
      ST_DRAIN   = 7'b0010000,
      ST_EMIT_RD = 7'b0100000,
      ST_EMIT_LD = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept && req_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SEG;
         end
         ST_SEG: begin
            cmd.seg_step = 1'b1;
            if (sts.seg_last) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `OX_ASSERT(a_last_starts_prep, clock, reset, accept && req_last |=> state_ff == ST_PREP, "last item did not start crossover")
   `OX_ASSERT(a_seg_to_fill, clock, reset, state_ff == ST_SEG && sts.seg_last |=> state_ff == ST_FILL, "segment copy did not hand over to fill")

endmodule

### hdl/ox_dpath.sv
// ----------------------------------------------------------------------------
// Ordered crossover datapath
// Parent and child stores, seen bits, cut handling, walk counters and the
// response output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ox_dpath (
   input  logic            clock,
   input  logic            reset,
   input  ox_pkg::req_type req_data,
   input  ox_pkg::cmd_type cmd,
   output ox_pkg::sts_type sts,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output ox_pkg::rsp_type rsp_data
);
   import ox_pkg::*;

   // Stores
   logic [NODE_W-1:0] a_mem [MAX_NODES];
   logic [NODE_W-1:0] b_mem [MAX_NODES];
   logic [NODE_W-1:0] child_mem [MAX_NODES];
   logic [NODE_RANGE-1:0] seen_ff;
   logic [MAX_NODES-1:0]  cvalid_ff;

   // Run registers
   logic [CNT_W-1:0]  load_cnt_ff;
   logic [CUT_W-1:0]  raw_s_ff;
   logic [CUT_W-1:0]  raw_e_ff;
   logic [CNT_W-1:0]  dim_ff;
   logic [ADDR_W-1:0] seg_s_ff;
   logic [CNT_W-1:0]  seg_e_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [ADDR_W-1:0] lo_ff;
   logic [CNT_W-1:0]  hi_ff;

   // Read pipeline
   logic              a_wb_ff;
   logic              b_wb_ff;
   logic [ADDR_W-1:0] a_pos_ff;
   logic [NODE_W-1:0] a_rd_ff;
   logic [NODE_W-1:0] b_rd_ff;
   logic [NODE_W-1:0] c_rd_ff;
   logic              c_vld_rd_ff;

   // Output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // Cut handling
   logic [CNT_W-1:0] dm1;
   logic [CNT_W-1:0] s_clamp;
   logic [CNT_W-1:0] e_clamp;
   logic [CNT_W-1:0] cut_lo;
   logic [CNT_W-1:0] cut_hi;

   // Child and seen writes
   logic              child_we;
   logic [ADDR_W-1:0] child_waddr;
   logic [NODE_W-1:0] child_wdata;
   logic              seen_we;
   logic [NODE_W-1:0] seen_node;
   logic              b_hit;
   logic              b_to_lo;
   logic              b_to_hi;
   logic [CNT_W-1:0]  idx_next;

   // Clamp, order and widen the cut points
   always_comb begin
      dm1     = load_cnt_ff - CNT_W'(1);
      s_clamp = (32'(raw_s_ff) >= 32'(load_cnt_ff)) ? dm1 : CNT_W'(raw_s_ff);
      e_clamp = (32'(raw_e_ff) >= 32'(load_cnt_ff)) ? dm1 : CNT_W'(raw_e_ff);
      cut_lo  = (s_clamp > e_clamp) ? e_clamp : s_clamp;
      cut_hi  = (s_clamp > e_clamp) ? s_clamp : e_clamp;
      if (cut_lo == cut_hi) begin
         if (cut_lo == '0) begin
            cut_hi = cut_hi + CNT_W'(1);
         end else begin
            cut_lo = cut_lo - CNT_W'(1);
         end
      end
   end

   // Walk status
   assign idx_next      = CNT_W'(idx_ff) + CNT_W'(1);
   assign sts.seg_last  = (idx_next == seg_e_ff);
   assign sts.fill_last = (idx_next == dim_ff);
   assign sts.emit_last = (idx_next == dim_ff);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // Fill placement of a parent B node
   always_comb begin
      b_hit   = (32'(b_rd_ff) < NODE_RANGE) && seen_ff[SEEN_W'(b_rd_ff)];
      b_to_lo = b_wb_ff && !b_hit && (lo_ff < seg_s_ff);
      b_to_hi = b_wb_ff && !b_hit && !(lo_ff < seg_s_ff) && (hi_ff < dim_ff);
   end

   // Child and seen write selection
   always_comb begin
      child_we    = 1'b0;
      child_waddr = a_pos_ff;
      child_wdata = a_rd_ff;
      seen_we     = 1'b0;
      seen_node   = a_rd_ff;
      if (a_wb_ff) begin
         child_we = 1'b1;
         seen_we  = 1'b1;
      end else if (b_wb_ff && !b_hit) begin
         child_we    = b_to_lo || b_to_hi;
         child_waddr = b_to_lo ? lo_ff : ADDR_W'(hi_ff);
         child_wdata = b_rd_ff;
         seen_we     = 1'b1;
         seen_node   = b_rd_ff;
      end
   end

   // Parent stores: write on load, read at the walk index
   always_ff @(posedge clock) begin
      if (cmd.load && (load_cnt_ff < CNT_W'(MAX_NODES))) begin
         a_mem[load_cnt_ff[ADDR_W-1:0]] <= req_data.parent_a_node;
         b_mem[load_cnt_ff[ADDR_W-1:0]] <= req_data.parent_b_node;
      end
      a_rd_ff <= a_mem[idx_ff];
      b_rd_ff <= b_mem[idx_ff];
   end

   // Child store
   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_waddr] <= child_wdata;
      end
      if (cmd.emit_read) begin
         c_rd_ff <= child_mem[idx_ff];
      end
   end

   // Seen bits and child valid bits; clear per run
   always_ff @(posedge clock) begin
      if (reset || cmd.prep) begin
         seen_ff   <= '0;
         cvalid_ff <= '0;
      end else begin
         if (seen_we && (32'(seen_node) < NODE_RANGE)) begin
            seen_ff[SEEN_W'(seen_node)] <= 1'b1;
         end
         if (child_we) begin
            cvalid_ff[child_waddr] <= 1'b1;
         end
      end
   end

   // Load count, cut capture, walk counters
   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         raw_s_ff    <= '0;
         raw_e_ff    <= '0;
         dim_ff      <= '0;
         seg_s_ff    <= '0;
         seg_e_ff    <= '0;
         idx_ff      <= '0;
         lo_ff       <= '0;
         hi_ff       <= '0;
         a_wb_ff     <= 1'b0;
         b_wb_ff     <= 1'b0;
      end else begin
         a_wb_ff <= cmd.seg_step;
         b_wb_ff <= cmd.fill_step;
         if (cmd.load) begin
            if (load_cnt_ff == '0) begin
               raw_s_ff <= req_data.cut_first;
               raw_e_ff <= req_data.cut_second;
            end
            if (load_cnt_ff < CNT_W'(MAX_NODES)) begin
               load_cnt_ff <= load_cnt_ff + CNT_W'(1);
            end
         end
         if (cmd.prep) begin
            dim_ff      <= load_cnt_ff;
            load_cnt_ff <= '0;
            seg_s_ff    <= ADDR_W'(cut_lo);
            seg_e_ff    <= cut_hi;
            idx_ff      <= ADDR_W'(cut_lo);
            lo_ff       <= '0;
            hi_ff       <= cut_hi;
         end
         if (cmd.seg_step) begin
            a_pos_ff <= idx_ff;
            idx_ff   <= sts.seg_last ? '0 : ADDR_W'(idx_next);
         end
         if (cmd.fill_step || cmd.emit_load) begin
            idx_ff <= (idx_next == dim_ff) ? '0 : ADDR_W'(idx_next);
         end
         if (b_to_lo) begin
            lo_ff <= lo_ff + ADDR_W'(1);
         end
         if (b_to_hi) begin
            hi_ff <= hi_ff + CNT_W'(1);
         end
      end
   end

   // Child valid bit beside the read data
   always_ff @(posedge clock) begin
      if (cmd.emit_read) begin
         c_vld_rd_ff <= cvalid_ff[idx_ff];
      end
   end

   // Output register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_data_ff.child_node     <= c_vld_rd_ff ? c_rd_ff : '0;
         rsp_data_ff.child_position <= POS_W'(idx_ff);
         rsp_data_ff.last_result    <= sts.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `OX_ASSERT(a_seg_nonempty, clock, reset, cmd.prep |=> CNT_W'(seg_s_ff) < seg_e_ff, "empty segment after cut handling")
   `OX_ASSERT(a_seg_write_in_range, clock, reset, a_wb_ff |-> (a_pos_ff >= seg_s_ff) && (CNT_W'(a_pos_ff) < seg_e_ff), "segment copy outside the segment")
   `OX_ASSERT_NEVER(a_lo_past_start, clock, reset, lo_ff > seg_s_ff, "front fill ran into the segment")
   `OX_ASSERT_NEVER(a_hi_past_dim, clock, reset, hi_ff > dim_ff, "back fill ran past the tour")

endmodule

### hdl/ordered_crossover_core.sv
// ----------------------------------------------------------------------------
// Ordered crossover core
// OX1 crossover of two parent tours loaded one position per item; emits the
// child tour one position per item.
//
//   channel  dir  contents
//   req_ch   in   parent A node, parent B node, cut points, last flag
//   rsp_ch   out  child node, child position, last flag
//
// Items load back to back while the core is idle. After the last item the
// run preps, copies the segment from parent A and fills from parent B,
// bounded by the single port of each parent store, then reads each child
// position through the child store read port and the output register. Input
// is held off from the last item until the final child position is in the
// output register. Reset is synchronous; a stalled result holds the readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_crossover_core (
   input  logic     clock,
   input  logic     reset,
   ox_req_if.sink   req_ch,
   ox_rsp_if.source rsp_ch
);
   import ox_pkg::*;

   req_type req_data;
   rsp_type rsp_data;
   cmd_type cmd;
   sts_type sts;
   logic    req_ready;
   logic    rsp_valid;

   // Gather the request payload
   assign req_data.parent_a_node = req_ch.parent_a_node;
   assign req_data.parent_b_node = req_ch.parent_b_node;
   assign req_data.cut_first     = req_ch.cut_first;
   assign req_data.cut_second    = req_ch.cut_second;
   assign req_data.last_item     = req_ch.last_item;
   assign req_ch.ready           = req_ready;

   ox_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_item),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ox_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Drive the response channel
   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.child_node     = rsp_data.child_node;
   assign rsp_ch.child_position = rsp_data.child_position;
   assign rsp_ch.last_result    = rsp_data.last_result;

endmodule

### tb/ordered_crossover_core_tb.sv
// ----------------------------------------------------------------------------
// Ordered crossover core testbench
// Loads runs of parent tours through the request channel and checks every
// child position against a local crossover predictor kept in a scoreboard.
// Directed runs cover single and tiny tours, reversed, equal and clamped
// cuts, and duplicate nodes. Random runs follow, one of them overflowing the
// node store. The sender idles in bursts and the receiver stalls on its own
// pattern, with one long hold-off that backs the core up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_crossover_core_tb;
   import ox_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 400;
   localparam int RUN_DEPTH    = 80;
   localparam int RANDOM_ITEMS = 130;
   localparam int MAX_REPORTS  = 10;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_e;

   // -------------------------------------------------------------------------
   // Scoreboard: crossover predictor and queue of expected child positions
   // -------------------------------------------------------------------------
   class crossover_scoreboard;
      logic [NODE_W-1:0] parent_a [MAX_NODES];
      logic [NODE_W-1:0] parent_b [MAX_NODES];
      int unsigned       loaded;
      logic [CUT_W-1:0]  raw_first;
      logic [CUT_W-1:0]  raw_second;
      rsp_type           expected_child [$];
      int                errors;
      int                checked;

      // Store one parent position; on the last one, predict the whole child
      function void note_parent_item(req_type item);
         int                dim;
         int                seg_lo;
         int                seg_hi;
         int                swap;
         int                fill_lo;
         int                fill_hi;
         bit                placed [NODE_RANGE];
         logic [NODE_W-1:0] child [MAX_NODES];
         logic [NODE_W-1:0] node;
         rsp_type           res;

         // Cuts come only with the first item of a run
         if (loaded == 0) begin
            raw_first  = item.cut_first;
            raw_second = item.cut_second;
         end
         // Drop positions past the store depth
         if (loaded < MAX_NODES) begin
            parent_a[loaded] = item.parent_a_node;
            parent_b[loaded] = item.parent_b_node;
            loaded++;
         end
         if (!item.last_item) return;

         // Clamp, order and widen the segment
         dim    = loaded;
         seg_lo = raw_first;
         seg_hi = raw_second;
         if (seg_lo >= dim) seg_lo = dim - 1;
         if (seg_hi >= dim) seg_hi = dim - 1;
         if (seg_lo > seg_hi) begin
            swap   = seg_lo;
            seg_lo = seg_hi;
            seg_hi = swap;
         end
         if (seg_lo == seg_hi) begin
            if (seg_lo == 0) seg_hi++;
            else seg_lo--;
         end

         for (int i = 0; i < NODE_RANGE; i++) placed[i] = 1'b0;
         for (int i = 0; i < MAX_NODES; i++) child[i] = '0;

         // Copy A's segment in place
         for (int i = seg_lo; i < seg_hi; i++) begin
            child[i]              = parent_a[i];
            placed[parent_a[i]]   = 1'b1;
         end

         // Fill from B in order: before the segment, then after it
         fill_lo = 0;
         fill_hi = seg_hi;
         for (int n = 0; n < dim; n++) begin
            node = parent_b[n];
            if (!placed[node]) begin
               if (fill_lo < seg_lo) begin
                  child[fill_lo] = node;
                  fill_lo++;
               end else if (fill_hi < dim) begin
                  child[fill_hi] = node;
                  fill_hi++;
               end
               placed[node] = 1'b1;
            end
         end

         for (int i = 0; i < dim; i++) begin
            res.child_node     = child[i];
            res.child_position = i[POS_W-1:0];
            res.last_result    = (i == dim - 1);
            expected_child.push_back(res);
         end
         loaded = 0;
      endfunction

      // Compare one child position with the oldest expectation
      function void check_child_item(rsp_type got);
         rsp_type want;

         checked++;
         if (expected_child.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("[%0t] unexpected child item: node %0d pos %0d last %0b",
                        $time, got.child_node, got.child_position, got.last_result);
            return;
         end
         want = expected_child.pop_front();
         if (got.child_node !== want.child_node ||
             got.child_position !== want.child_position ||
             got.last_result !== want.last_result) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("[%0t] child mismatch: exp node %0d pos %0d last %0b, got node %0d pos %0d last %0b",
                        $time, want.child_node, want.child_position, want.last_result,
                        got.child_node, got.child_position, got.last_result);
         end
      endfunction

      function int pending();
         return expected_child.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the core
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;

   ox_req_if req_if ();
   ox_rsp_if rsp_if ();

   ordered_crossover_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   crossover_scoreboard sb;

   logic [NODE_W-1:0] run_a [RUN_DEPTH];
   logic [NODE_W-1:0] run_b [RUN_DEPTH];
   int                burst_left;
   int                cycle_count;
   int                items_sent;
   int                runs_sent;
   int                max_len;
   bit                overflow_done;
   bit                long_hold_done;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Abort on a run that never drains
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[%0t] timeout with %0d child items pending", $time, sb.pending());
         $display("FAIL ordered_crossover_core");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.child_node     = rsp_if.child_node;
         got.child_position = rsp_if.child_position;
         got.last_result    = rsp_if.last_result;
         sb.check_child_item(got);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stall pattern in stretches, one long hold-off
   // -------------------------------------------------------------------------
   initial begin
      stall_mode_e mode;
      int          span;

      rsp_if.ready   <= 1'b0;
      long_hold_done  = 1'b0;
      repeat (RESET_CYCLES + 1) @(posedge clock);
      forever begin
         mode = stall_mode_e'($urandom_range(0, 3));
         span = $urandom_range(16, 64);
         repeat (span) begin
            @(posedge clock);
            if (!long_hold_done && sb.checked >= 30) begin
               // Back the core up into its input
               long_hold_done = 1'b1;
               rsp_if.ready  <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end else begin
               case (mode)
                  STALL_NONE:  rsp_if.ready <= 1'b1;
                  STALL_LIGHT: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                  STALL_HALF:  rsp_if.ready <= $urandom_range(0, 1);
                  default:     rsp_if.ready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Distinct random nodes for A, B a shuffle of the same set
   task automatic fill_permutation(input int len);
      logic [NODE_W-1:0] pool [NODE_RANGE];
      logic [NODE_W-1:0] tmp;
      int                j;

      for (int i = 0; i < NODE_RANGE; i++) pool[i] = i[NODE_W-1:0];
      for (int i = 0; i < len; i++) begin
         j       = $urandom_range(i, NODE_RANGE - 1);
         tmp     = pool[i];
         pool[i] = pool[j];
         pool[j] = tmp;
         run_a[i] = pool[i];
         run_b[i] = pool[i];
      end
      for (int i = len - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = run_b[i];
         run_b[i] = run_b[j];
         run_b[j] = tmp;
      end
   endtask

   // Send one run; cuts go on the first item, noise cuts on the rest
   task automatic send_run(input int len, input int cut_a, input int cut_b);
      req_type item;

      for (int i = 0; i < len; i++) begin
         item.parent_a_node = run_a[i];
         item.parent_b_node = run_b[i];
         item.cut_first     = (i == 0) ? cut_a[CUT_W-1:0] : CUT_W'($urandom_range(0, 63));
         item.cut_second    = (i == 0) ? cut_b[CUT_W-1:0] : CUT_W'($urandom_range(0, 63));
         item.last_item     = (i == len - 1);

         // Idle between bursts
         if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
         end

         req_if.valid         <= 1'b1;
         req_if.parent_a_node <= item.parent_a_node;
         req_if.parent_b_node <= item.parent_b_node;
         req_if.cut_first     <= item.cut_first;
         req_if.cut_second    <= item.cut_second;
         req_if.last_item     <= item.last_item;
         do @(posedge clock); while (!req_if.ready);
         sb.note_parent_item(item);
         burst_left--;
         items_sent++;
      end
      runs_sent++;
      if (len > max_len) max_len = len;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int len;
      int kind;
      int cut_a;
      int cut_b;
      int random_items;

      sb = new;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.parent_a_node <= '0;
      req_if.parent_b_node <= '0;
      req_if.cut_first     <= '0;
      req_if.cut_second    <= '0;
      req_if.last_item     <= 1'b0;
      burst_left    = 0;
      items_sent    = 0;
      runs_sent     = 0;
      max_len       = 0;
      overflow_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single position with cuts past the end
      fill_permutation(1);
      run_a[0] = 8'hFF;
      run_b[0] = 8'h00;
      send_run(1, 63, 63);
      // Equal cuts at zero
      fill_permutation(2);
      send_run(2, 0, 0);
      // Reversed cuts
      fill_permutation(3);
      send_run(3, 2, 0);
      // Equal cuts away from zero
      fill_permutation(4);
      send_run(4, 2, 2);
      // Both cuts past the end
      fill_permutation(4);
      send_run(4, 63, 40);
      // Duplicates in B and a child position left unfilled
      run_a[0] = 8'h00; run_b[0] = 8'hFF;
      run_a[1] = 8'hFF; run_b[1] = 8'hFF;
      run_a[2] = 8'h07; run_b[2] = 8'h00;
      run_a[3] = 8'h08; run_b[3] = 8'h00;
      run_a[4] = 8'h09; run_b[4] = 8'hC8;
      send_run(5, 1, 3);
      // Widest cut span
      fill_permutation(5);
      send_run(5, 0, 63);

      // Random runs, mostly well-formed tours
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (!overflow_done && random_items >= 40) begin
            // Overflow the node store with extreme cuts
            fill_permutation(66);
            send_run(66, 63, 0);
            overflow_done = 1'b1;
            random_items += 66;
         end else begin
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(2, 12);
            fill_permutation(len);
            if (kind == 7 || kind == 8) begin
               // Break the tour: overwrite a few B nodes
               repeat ($urandom_range(1, 3))
                  run_b[$urandom_range(0, len - 1)] = NODE_W'($urandom_range(0, 255));
            end else if (kind == 9) begin
               // Pure noise on both parents
               for (int i = 0; i < len; i++) begin
                  run_a[i] = NODE_W'($urandom_range(0, 255));
                  run_b[i] = NODE_W'($urandom_range(0, 255));
               end
            end
            if ($urandom_range(0, 9) < 7) begin
               cut_a = $urandom_range(0, len - 1);
               cut_b = $urandom_range(0, len - 1);
            end else begin
               cut_a = $urandom_range(0, 63);
               cut_b = $urandom_range(0, 63);
            end
            send_run(len, cut_a, cut_b);
            random_items += len;
         end
      end
      req_if.valid <= 1'b0;

      // Drain, then watch for stray results
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d crossover runs from %0d parent items, tours of 1 to %0d positions.",
               runs_sent, items_sent, max_len);
      $display("Checked %0d child items, store overflow %0s, long output hold-off %0s.",
               sb.checked, overflow_done ? "hit" : "missed",
               long_hold_done ? "hit" : "missed");
      if (sb.errors == 0) begin
         $display("PASS ordered_crossover_core");
      end else begin
         $display("%0d failures", sb.errors);
         $display("FAIL ordered_crossover_core");
      end
      $finish;
   end

endmodule
